### rtl/cft_pkg.sv
package cft_pkg;

    typedef enum logic [1:0] {
        MODE_SET  = 2'd0,
        MODE_GET  = 2'd1,
        MODE_DEL  = 2'd2,
        MODE_PEEK = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2,
        ST_ABSENT   = 2'd3
    } t_status;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [3:0]  new_state;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [3:0]  state_out;
        t_status     status;
    } t_rsp;

    typedef enum logic [2:0] {
        F_IDLE,
        F_H1,
        F_H2,
        F_M1,
        F_M2,
        F_FIX
    } t_front_state;

    typedef enum logic [1:0] {
        B_CLR,
        B_IDLE,
        B_EXEC
    } t_back_state;

    localparam int KEY_BITS = 96;

    function automatic logic [31:0] mix32(input logic [31:0] x);
        logic [31:0] v;
        v = x ^ ~(x << 15);
        v = v + (v >> 10);
        v = v ^ (v << 3);
        v = v + ~(v >> 16);
        return v;
    endfunction

    function automatic logic [31:0] pair_mix(input logic [31:0] a, input logic [31:0] b);
        return mix32((a << 3) ^ (b >> 2) ^ (a >> 3) ^ (b << 4));
    endfunction

endpackage

### rtl/cft_fifo.sv
module cft_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule

### rtl/cft_front.sv
module cft_front #(
    parameter int BUCKETS = 1024,
    parameter int BW      = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  cft_pkg::t_req                        i_req,
    output logic                                 o_push,
    output logic [BW+$bits(cft_pkg::t_req)-1:0]  o_job,
    input  logic                                 i_full
);
    import cft_pkg::*;

    // floor(2^32 / BUCKETS); estimate of the quotient is low by at most one
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / BUCKETS);

    t_front_state r_state, n_state;
    t_req         r_req;
    logic [31:0]  r_h;
    logic [31:0]  r_q;
    logic [31:0]  r_qb;
    logic [64:0]  prod;
    logic [47:0]  qb;
    logic [31:0]  rem;
    logic [31:0]  rem_fix;

    assign prod    = 65'(r_h) * 65'(RECIP);
    assign qb      = 48'(r_q) * 48'(BUCKETS);
    assign rem     = r_h - r_qb;
    assign rem_fix = (rem >= 32'(BUCKETS)) ? rem - 32'(BUCKETS) : rem;
    assign o_job   = {rem_fix[BW-1:0], r_req};

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (i_valid) n_state = F_H1;
            F_H1:    n_state = F_H2;
            F_H2:    n_state = F_M1;
            F_M1:    n_state = F_M2;
            F_M2:    n_state = F_FIX;
            F_FIX:   if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == F_IDLE);
        o_push  = (r_state == F_FIX) && !i_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= F_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE:  if (i_valid) r_req <= i_req;
            F_H1:    r_h  <= pair_mix(r_req.src_addr, r_req.dst_addr);
            F_H2:    r_h  <= pair_mix(r_h, {r_req.dst_port, r_req.src_port});
            F_M1:    r_q  <= prod[63:32];
            F_M2:    r_qb <= qb[31:0];
            default: ;
        endcase
    end
endmodule

### rtl/cft_back.sv
module cft_back #(
    parameter int BUCKETS    = 1024,
    parameter int WAYS       = 4,
    parameter int STATE_BITS = 4,
    parameter int BW         = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [BW+$bits(cft_pkg::t_req)-1:0]  i_job,
    input  logic                                 i_empty,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output cft_pkg::t_rsp                        o_rsp
);
    import cft_pkg::*;

    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SB = STATE_BITS;

    logic [WAYS*KEY_BITS-1:0] r_key_mem [BUCKETS];
    logic [WAYS*SB-1:0]       r_st_mem  [BUCKETS];
    logic [WAYS-1:0]          r_vld_mem [BUCKETS];

    t_back_state              r_state, n_state;
    logic [BW-1:0]            r_clr;
    logic [BW-1:0]            r_bucket;
    t_req                     r_req;
    logic [WAYS*KEY_BITS-1:0] r_key_rd;
    logic [WAYS*SB-1:0]       r_st_rd;
    logic [WAYS-1:0]          r_vld_rd;
    logic                     r_out_valid;
    t_rsp                     r_rsp;

    logic                     go;
    logic                     row_we;
    logic                     vld_we;
    logic [BW-1:0]            vld_addr;
    logic [WAYS-1:0]          vld_wdata;
    logic [WAYS*KEY_BITS-1:0] key_row;
    logic [WAYS*SB-1:0]       st_row;
    logic [WAYS-1:0]          vld_row;
    logic [KEY_BITS-1:0]      key;
    logic                     hit;
    logic                     have_free;
    logic [WW-1:0]            hit_w;
    logic [WW-1:0]            free_w;
    logic [SB-1:0]            ns;
    t_rsp                     rsp;

    assign key     = {r_req.src_addr, r_req.dst_addr, r_req.src_port, r_req.dst_port};
    assign ns      = SB'(r_req.new_state);
    assign go      = !r_out_valid || i_ready;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    // way search: first matching valid way, first free way
    always_comb begin
        hit       = 1'b0;
        have_free = 1'b0;
        hit_w     = '0;
        free_w    = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (r_vld_rd[w]) begin
                if (!hit && r_key_rd[w*KEY_BITS +: KEY_BITS] == key) begin
                    hit   = 1'b1;
                    hit_w = WW'(w);
                end
            end else if (!have_free) begin
                have_free = 1'b1;
                free_w    = WW'(w);
            end
        end
    end

    always_comb begin
        key_row       = r_key_rd;
        st_row        = r_st_rd;
        vld_row       = r_vld_rd;
        rsp.found     = hit;
        rsp.state_out = '0;
        rsp.status    = hit ? ST_DONE : ST_ABSENT;
        case (r_req.mode)
            MODE_SET: begin
                if (hit) begin
                    st_row[hit_w*SB +: SB] = ns;
                end else if (have_free) begin
                    key_row[free_w*KEY_BITS +: KEY_BITS] = key;
                    st_row[free_w*SB +: SB]              = ns;
                    vld_row[free_w]                      = 1'b1;
                    rsp.status                           = ST_INSERTED;
                end else begin
                    rsp.status = ST_FULL;
                end
            end
            MODE_GET: if (hit) rsp.state_out = 4'(r_st_rd[hit_w*SB +: SB]);
            MODE_DEL: if (hit) vld_row[hit_w] = 1'b0;
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_CLR:   if (r_clr == BW'(BUCKETS - 1)) n_state = B_IDLE;
            B_IDLE:  if (!i_empty) n_state = B_EXEC;
            B_EXEC:  if (go) n_state = B_IDLE;
            default: n_state = B_CLR;
        endcase
    end

    always_comb begin
        o_pop     = (r_state == B_IDLE) && !i_empty;
        row_we    = (r_state == B_EXEC) && go;
        vld_we    = (r_state == B_CLR) || row_we;
        vld_addr  = (r_state == B_CLR) ? r_clr : r_bucket;
        vld_wdata = (r_state == B_CLR) ? '0 : vld_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLR) r_clr <= r_clr + 1'b1;
            if (row_we)           r_out_valid <= 1'b1;
            else if (i_ready)     r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bucket <= i_job[$bits(t_req) +: BW];
            r_req    <= i_job[$bits(t_req)-1:0];
            r_key_rd <= r_key_mem[i_job[$bits(t_req) +: BW]];
            r_st_rd  <= r_st_mem[i_job[$bits(t_req) +: BW]];
            r_vld_rd <= r_vld_mem[i_job[$bits(t_req) +: BW]];
        end
        if (row_we) begin
            r_key_mem[r_bucket] <= key_row;
            r_st_mem[r_bucket]  <= st_row;
            r_rsp               <= rsp;
        end
        if (vld_we) r_vld_mem[vld_addr] <= vld_wdata;
    end

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty) else $error("pop from empty queue");
    a_clr_first: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_state == B_CLR || !i_rst_n)) else $error("clear pass skipped");
    a_insert_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_rsp.status == ST_INSERTED || o_rsp.status == ST_FULL) |-> !o_rsp.found)
        else $error("insert reported on hit");
    a_no_work_in_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CLR) |-> !o_pop && !row_we) else $error("request during clear");
endmodule

### rtl/connection_flow_table.sv
// channel  | valid   | ready   | beat
// request  | i_valid | o_ready | i_req  (mode, four-tuple, new_state)
// response | o_valid | i_ready | o_rsp  (found, state_out, status)
//
// Front: one request at a time in hash and bucket reduction (H1, H2, M1, M2, FIX) before the queue.
// Back: registered bucket row read, then compare/write-back; queue is 2 deep.
// The front hash sequencer accepts a new request only after its last one is queued.
// After reset the valid marks are swept, one bucket per cycle;
// requests queue up during that time and are served after it.
// A stalled response holds the back; the front keeps filling the queue until it is full.
module connection_flow_table #(
    parameter int BUCKETS    = 1024,
    parameter int WAYS       = 4,
    parameter int STATE_BITS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cft_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output cft_pkg::t_rsp o_rsp
);
    import cft_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int JW = BW + $bits(t_req);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    logic [JW-1:0] job_in;
    logic [JW-1:0] job_out;

    cft_front #(.BUCKETS(BUCKETS), .BW(BW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_push  (push),
        .o_job   (job_in),
        .i_full  (full)
    );

    cft_fifo #(.W(JW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_full  (full),
        .o_empty (empty)
    );

    cft_back #(
        .BUCKETS    (BUCKETS),
        .WAYS       (WAYS),
        .STATE_BITS (STATE_BITS),
        .BW         (BW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_out),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );
endmodule
